### src/stx_pkg.sv
// stx_pkg: shared types, character constants and helpers of the s-expression tokenizer
// no dependencies; imported by every module in src

package stx_pkg;

    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 31;
    localparam int DATA_OUT_W  = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PROD_W      = VALUE_W + 4;

    localparam logic [VALUE_W-1:0] NUM_MAX = {VALUE_W{1'b1}};
    localparam logic [3:0]         RADIX   = 4'd10;

    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;

    typedef enum logic [3:0] {
        K_END     = 4'd0,
        K_NUMBER  = 4'd1,
        K_LPAR    = 4'd2,
        K_RPAR    = 4'd3,
        K_QUOTE   = 4'd4,
        K_DOT     = 4'd5,
        K_STRCHAR = 4'd6,
        K_STREND  = 4'd7,
        K_SYMCHAR = 4'd8,
        K_SYMEND  = 4'd9
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic               overflowed;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_input;
    } t_item;

    // results of one lexer step, first goes out first
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_step_out;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c <= CH_SPACE) || c[CHAR_W-1];
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic t_result make_result(input t_kind k, input logic [VALUE_W-1:0] v,
                                            input logic ovf);
        t_result r;
        r.kind       = k;
        r.value      = v;
        r.overflowed = ovf;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

### src/s_expression_tokenizer.sv
// s_expression_tokenizer: top level, input register, lexer step and result queue
// depends on stx_pkg, stx_lexer, stx_out_queue
//
//  channel | direction | tdata                                   | tuser / tlast
//  --------+-----------+-----------------------------------------+-------------------------
//  s       | in        | [7:0] char_code                         | tuser[0] end_of_input
//  m       | out       | [3:0] kind, [34:4] value, [35] overflowed| tlast = last of request
//
// one input request a cycle while the queue has room; each gives zero, one or two results
// a request is held in the input register, lexed in one pass and its results written
//   to a four-entry queue; throughput is set by the result side at one result a cycle
// a new request is taken while the input register is empty or its request is lexed
// synchronous active-low reset returns the lexer to idle and empties the queue
// an output stall fills the queue; the held request waits for room for two results

module s_expression_tokenizer
    import stx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [CHAR_W-1:0]     i_s_tdata,   // [7:0] char_code
    input  logic [0:0]            i_s_tuser,   // [0] end_of_input
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [DATA_OUT_W-1:0] o_m_tdata,   // [3:0] kind, [34:4] value, [35] overflowed
    output logic                  o_m_tlast
);

    logic      r_in_valid;
    t_item     r_item;
    logic      room;
    logic      step;
    t_step_out step_out;
    t_result   head;

    // the held request is lexed as soon as the queue can take both its results
    assign step       = r_in_valid && room;
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.char_code    <= i_s_tdata;
            r_item.end_of_input <= i_s_tuser[0];
        end
    end

    stx_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .o_out   (step_out)
    );

    stx_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (step_out),
        .o_room   (room),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (head)
    );

    // pack result fields from the lowest bit up, zero padding to whole bytes
    assign o_m_tdata = DATA_OUT_W'({head.overflowed, head.value, head.kind});
    assign o_m_tlast = head.last;

endmodule

### src/stx_lexer.sv
// stx_lexer: lexer mode, number accumulator and end flag, one step per fired request
// depends on stx_pkg

module stx_lexer
    import stx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_item     i_item,
    output t_step_out o_out
);

    typedef enum logic [1:0] {
        M_IDLE   = 2'd0,
        M_NUMBER = 2'd1,
        M_STRING = 2'd2,
        M_SYMBOL = 2'd3
    } t_mode;

    t_mode              r_mode, n_mode;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic               r_sat, n_sat;
    logic               r_ended, n_ended;

    logic [CHAR_W-1:0]  c;
    logic [3:0]         digit;
    logic [PROD_W-1:0]  prod;

    // what the byte does when seen in idle mode
    logic               idle_emit;
    t_result            idle_res;
    t_mode              idle_mode;

    t_step_out          step;

    assign c     = i_item.char_code;
    assign digit = 4'(c - CH_ZERO);
    assign prod  = PROD_W'(r_acc) * PROD_W'(RADIX) + PROD_W'(digit);

    always_comb begin
        idle_emit = 1'b0;
        idle_res  = make_result(K_END, '0, 1'b0);
        idle_mode = M_IDLE;
        if (is_space(c)) begin
            idle_mode = M_IDLE;
        end else if (is_digit(c)) begin
            idle_mode = M_NUMBER;
        end else begin
            unique case (c)
                CH_LPAR: begin
                    idle_emit = 1'b1;
                    idle_res  = make_result(K_LPAR, '0, 1'b0);
                end
                CH_RPAR: begin
                    idle_emit = 1'b1;
                    idle_res  = make_result(K_RPAR, '0, 1'b0);
                end
                CH_QUOTE: begin
                    idle_emit = 1'b1;
                    idle_res  = make_result(K_QUOTE, '0, 1'b0);
                end
                CH_DOT: begin
                    idle_emit = 1'b1;
                    idle_res  = make_result(K_DOT, '0, 1'b0);
                end
                CH_DQUOTE: begin
                    idle_mode = M_STRING;
                end
                default: begin
                    idle_emit = 1'b1;
                    idle_res  = make_result(K_SYMCHAR, VALUE_W'(c), 1'b0);
                    idle_mode = M_SYMBOL;
                end
            endcase
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_acc        = r_acc;
        n_sat        = r_sat;
        n_ended      = r_ended;
        step.count   = 2'd0;
        step.first   = make_result(K_END, '0, 1'b0);
        step.second  = make_result(K_END, '0, 1'b0);

        if (r_ended) begin
            step.count = 2'd1;
        end else if (i_item.end_of_input) begin
            n_mode  = M_IDLE;
            n_ended = 1'b1;
            unique case (r_mode)
                M_NUMBER: begin
                    step.count = 2'd2;
                    step.first = make_result(K_NUMBER, r_acc, r_sat);
                end
                M_SYMBOL: begin
                    step.count = 2'd2;
                    step.first = make_result(K_SYMEND, '0, 1'b0);
                end
                M_STRING: begin
                    step.count = 2'd2;
                    step.first = make_result(K_STREND, '0, 1'b1);
                end
                default: begin
                    step.count = 2'd1;
                end
            endcase
        end else begin
            unique case (r_mode)
                M_NUMBER: begin
                    if (is_digit(c)) begin
                        if (prod > PROD_W'(NUM_MAX)) begin
                            n_acc = NUM_MAX;
                            n_sat = 1'b1;
                        end else begin
                            n_acc = prod[VALUE_W-1:0];
                        end
                    end else begin
                        // number closed, then the byte is lexed as in idle
                        step.first  = make_result(K_NUMBER, r_acc, r_sat);
                        step.second = idle_res;
                        step.count  = idle_emit ? 2'd2 : 2'd1;
                        n_mode      = idle_mode;
                    end
                end
                M_STRING: begin
                    step.count = 2'd1;
                    if (c == CH_DQUOTE) begin
                        step.first = make_result(K_STREND, '0, 1'b0);
                        n_mode     = M_IDLE;
                    end else begin
                        step.first = make_result(K_STRCHAR, VALUE_W'(c), 1'b0);
                    end
                end
                M_SYMBOL: begin
                    if (is_space(c)) begin
                        step.count = 2'd1;
                        step.first = make_result(K_SYMEND, '0, 1'b0);
                        n_mode     = M_IDLE;
                    end else if (c == CH_RPAR) begin
                        step.count  = 2'd2;
                        step.first  = make_result(K_SYMEND, '0, 1'b0);
                        step.second = make_result(K_RPAR, '0, 1'b0);
                        n_mode      = M_IDLE;
                    end else begin
                        step.count = 2'd1;
                        step.first = make_result(K_SYMCHAR, VALUE_W'(c), 1'b0);
                    end
                end
                default: begin
                    step.first = idle_res;
                    step.count = idle_emit ? 2'd1 : 2'd0;
                    n_mode     = idle_mode;
                    if (is_digit(c)) begin
                        n_acc = VALUE_W'(digit);
                        n_sat = 1'b0;
                    end
                end
            endcase
        end

        step.first.last  = (step.count == 2'd1);
        step.second.last = (step.count == 2'd2);
        if (!i_step) begin
            step.count = 2'd0;
        end
    end

    assign o_out = step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_acc   <= '0;
            r_sat   <= 1'b0;
            r_ended <= 1'b0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_sat   <= n_sat;
            r_ended <= n_ended;
        end
    end

endmodule

### src/stx_out_queue.sv
// stx_out_queue: small result queue, takes up to two results a cycle, gives one
// depends on stx_pkg

module stx_out_queue
    import stx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_step_out i_push,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_ready,
    output t_result   o_result
);

    t_result            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_head, r_tail;
    logic [QCNT_W-1:0]  r_count;
    logic               pop;
    logic [QPTR_W-1:0]  tail_next;

    assign o_valid   = (r_count != '0);
    assign pop       = o_valid && i_ready;
    assign o_result  = r_mem[r_head];
    // room for a two-result step, regardless of this cycle's pop
    assign o_room    = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign tail_next = r_tail + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[tail_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + QPTR_W'(i_push.count);
            r_head  <= r_head + QPTR_W'(pop);
            r_count <= r_count + QCNT_W'(i_push.count) - QCNT_W'(pop);
        end
    end

endmodule
